// ----- sv/obbo_pkg.sv -----
// Shared types and codes for the order book top-of-book unit.
// No dependencies; the level cell and the top level import this package.
package obbo_pkg;

   // request function codes
   localparam logic [2:0] FUNC_ADD    = 3'd0;
   localparam logic [2:0] FUNC_MODIFY = 3'd1;
   localparam logic [2:0] FUNC_CANCEL = 3'd2;
   localparam logic [2:0] FUNC_CLEAR  = 3'd3;

   // response status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_UNKNOWN = 2'd1;
   localparam logic [1:0] STAT_DUP     = 2'd2;
   localparam logic [1:0] STAT_CLASH   = 2'd3;

   localparam int TOTAL_W = 42;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // operation broadcast to the level cells
   typedef enum logic [2:0] {
      CELL_NOP,
      CELL_ADD,
      CELL_MODIFY,
      CELL_CANCEL,
      CELL_CLEAR
   } cell_op_type;

   // command bus from the sequencer to every level cell
   typedef struct packed {
      cell_op_type  op;
      logic [15:0]  slot;
      logic         side;
      logic [31:0]  price;
      logic [31:0]  quantity;
      logic [31:0]  old_quantity;
   } cmd_type;

   // running top-of-book candidate passed down the cell chain
   typedef struct packed {
      logic               bid_valid;
      logic [31:0]        bid_price;
      logic [TOTAL_W-1:0] bid_total;
      logic               ask_valid;
      logic [31:0]        ask_price;
      logic [TOTAL_W-1:0] ask_total;
   } best_type;

   // one word of the order table
   typedef struct packed {
      logic        live;
      logic        side;
      logic [31:0] price;
      logic [31:0] quantity;
   } ord_rec_type;

endpackage

// ----- sv/obbo_channels.sv -----
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing.
interface obbo_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [9:0]  order_id;
   logic        side;
   logic [31:0] price;
   logic [31:0] quantity;

   modport source (output valid, func, order_id, side, price, quantity, input ready);
   modport sink   (input valid, func, order_id, side, price, quantity, output ready);
endinterface

interface obbo_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        bid_valid;
   logic [31:0] bid_price;
   logic [41:0] bid_total;
   logic        ask_valid;
   logic [31:0] ask_price;
   logic [41:0] ask_total;

   modport source (output valid, status, bid_valid, bid_price, bid_total,
                   ask_valid, ask_price, ask_total, input ready);
   modport sink   (input valid, status, bid_valid, bid_price, bid_total,
                   ask_valid, ask_price, ask_total, output ready);
endinterface

// ----- sv/obbo_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module obbo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- sv/obbo_level_cell.sv -----
// One price level slot of the book plus one stage of the best-price scan chain.
// Depends on obbo_pkg.
module obbo_level_cell #(
   parameter int IDX = 0,
   parameter int CW  = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  obbo_pkg::cmd_type  cmd,
   input  logic              tok_i,
   input  obbo_pkg::best_type cand_i,
   output logic              tok_o,
   output obbo_pkg::best_type cand_o,
   output logic              clash_o
);
   import obbo_pkg::*;

   logic [CW-1:0]      count_ff, count_in;
   logic               side_ff, side_in;
   logic [31:0]        price_ff, price_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               clash_ff, clash_in;
   logic               tok_ff;
   best_type           cand_ff, cand_in;

   logic               hit;
   logic               busy;
   logic [TOTAL_W-1:0] base;
   logic [TOTAL_W-1:0] add_src;
   logic [TOTAL_W:0]   sum;
   logic [TOTAL_W-1:0] sat_sum;
   logic [TOTAL_W-1:0] sub_res;

   assign hit  = (cmd.slot == 16'(IDX));
   assign busy = (count_ff != '0);

   // shared saturating add: plain add uses the old total, modify the reduced one
   assign sub_res = (total_ff >= TOTAL_W'(cmd.old_quantity)) ?
                    total_ff - TOTAL_W'(cmd.old_quantity) : '0;
   assign add_src = (cmd.op == CELL_MODIFY) ? sub_res : total_ff;
   assign base    = add_src;
   assign sum     = {1'b0, base} + (TOTAL_W+1)'(cmd.quantity);
   assign sat_sum = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

   always_comb begin
      count_in = count_ff;
      side_in  = side_ff;
      price_in = price_ff;
      total_in = total_ff;
      clash_in = hit && busy && ((side_ff != cmd.side) || (price_ff != cmd.price));
      case (cmd.op)
         CELL_ADD: begin
            if (hit) begin
               if (busy) begin
                  count_in = count_ff + 1'b1;
                  total_in = sat_sum;
               end else begin
                  count_in = CW'(1);
                  side_in  = cmd.side;
                  price_in = cmd.price;
                  total_in = TOTAL_W'(cmd.quantity);
               end
            end
         end
         CELL_MODIFY: begin
            if (hit) begin
               total_in = sat_sum;
            end
         end
         CELL_CANCEL: begin
            if (hit && busy) begin
               count_in = count_ff - 1'b1;
               total_in = sub_res;
            end
         end
         CELL_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // merge this level into the candidate; strict compares keep the lowest slot on ties
   always_comb begin
      cand_in = cand_i;
      if (busy) begin
         if (!side_ff) begin
            if (!cand_i.bid_valid || (price_ff > cand_i.bid_price)) begin
               cand_in.bid_valid = 1'b1;
               cand_in.bid_price = price_ff;
               cand_in.bid_total = total_ff;
            end
         end else begin
            if (!cand_i.ask_valid || (price_ff < cand_i.ask_price)) begin
               cand_in.ask_valid = 1'b1;
               cand_in.ask_price = price_ff;
               cand_in.ask_total = total_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         clash_ff <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         clash_ff <= clash_in;
         tok_ff   <= tok_i;
      end
      side_ff  <= side_in;
      price_ff <= price_in;
      total_ff <= total_in;
      cand_ff  <= cand_in;
   end

   assign tok_o   = tok_ff;
   assign cand_o  = cand_ff;
   assign clash_o = clash_ff;
endmodule

// ----- sv/order_book_best_bid_offer_unit.sv -----
// Order book top-of-book unit. One request at a time; an accepted add, modify or cancel
// goes through the table read, slot arithmetic, check, decide and apply states, then a
// scan token walks the LEVELS-long cell chain before it answers. Unknown or duplicate
// ids go to the scan straight after the table read, a slot clash after decide, a clear
// after the table sweep. A stalled response holds the next request. Sync reset runs a
// table sweep with req.ready low.
module order_book_best_bid_offer_unit #(
   parameter int MAX_ORDERS = 1024,
   parameter int LEVELS     = 256
) (
   input  logic       clock,
   input  logic       reset,
   obbo_req_if.sink   req,
   obbo_rsp_if.source rsp
);
   import obbo_pkg::*;

   localparam int IW   = $clog2(MAX_ORDERS);
   localparam int LW   = $clog2(LEVELS);
   localparam int CW   = $clog2(MAX_ORDERS + 1);
   localparam int RECW = $bits(ord_rec_type);

   // residue of each price bit weight 2^k modulo LEVELS
   typedef logic [31:0][LW-1:0] weight_type;

   function automatic weight_type residues();
      weight_type      w;
      longint unsigned v;
      v = 1;
      for (int k = 0; k < 32; k++) begin
         w[k] = LW'(v % LEVELS);
         v    = (v * 2) % LEVELS;
      end
      return w;
   endfunction

   localparam weight_type WEIGHTS = residues();

   // multiples of LEVELS used to fold the residue sum back below LEVELS
   localparam logic [LW+4:0] LV_X1  = (LW+5)'(LEVELS);
   localparam logic [LW+4:0] LV_X2  = (LW+5)'(2 * LEVELS);
   localparam logic [LW+4:0] LV_X4  = (LW+5)'(4 * LEVELS);
   localparam logic [LW+4:0] LV_X8  = (LW+5)'(8 * LEVELS);
   localparam logic [LW+4:0] LV_X16 = (LW+5)'(16 * LEVELS);

   typedef enum logic [3:0] {
      S_WIPE,    // order table sweep (after reset or clear)
      S_IDLE,    // ready for a request
      S_READ,    // order table word arrives
      S_MOD,     // price modulo LEVELS
      S_CHECK,   // cells register slot clash flags
      S_DECIDE,  // read clash flags
      S_APPLY,   // cells and order table update
      S_SCAN,    // best price token walks the chain
      S_DONE     // result waits for the output register
   } state_type;

   state_type          state_ff, state_in;
   logic [IW-1:0]      wipe_addr_ff, wipe_addr_in;
   logic               wipe_rsp_ff, wipe_rsp_in;
   logic [2:0]         func_ff, func_in;
   logic [9:0]         id_ff, id_in;
   logic               side_ff, side_in;
   logic [31:0]        price_ff, price_in;
   logic [31:0]        qty_ff, qty_in;
   logic [1:0]         status_ff, status_in;
   logic [31:0]        pbits_ff, pbits_in;
   logic [LW+1:0]      part_ff [8];
   logic [LW+1:0]      part_in [8];
   logic [LW+4:0]      rem_ff, rem_in;
   logic [1:0]         step_ff, step_in;
   cmd_type            cmd_ff, cmd_in;
   logic               scan_start_ff, scan_start_in;
   best_type           res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   best_type           rsp_best_ff, rsp_best_in;

   logic               ram_we;
   logic [IW-1:0]      ram_wa;
   ord_rec_type        ram_wd;
   logic               ram_re;
   logic [IW-1:0]      ram_ra;
   logic [RECW-1:0]    ram_rd;
   ord_rec_type        rec;

   logic               accept;
   logic               id_ok;
   logic [LW+1:0]      term [32];
   logic [LW+4:0]      part_ext [8];
   logic [LW+4:0]      fold16, fold8, fold4, fold2, fold1;

   logic [LEVELS-1:0]  tok;
   logic [LEVELS-1:0]  clash;
   best_type           cand [LEVELS];

   assign accept  = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign ram_re  = accept;
   assign ram_ra  = IW'({22'b0, req.order_id});
   assign rec     = ord_rec_type'(ram_rd);
   assign id_ok   = ({22'b0, id_ff} < 32'(MAX_ORDERS));

   // slot arithmetic: residues of set price bits, then fold by multiples of LEVELS
   always_comb begin
      for (int k = 0; k < 32; k++) begin
         term[k] = pbits_ff[k] ? (LW+2)'(WEIGHTS[k]) : '0;
      end
      for (int g = 0; g < 8; g++) begin
         part_ext[g] = (LW+5)'(part_ff[g]);
      end
   end

   assign fold16 = (rem_ff >= LV_X16) ? rem_ff - LV_X16 : rem_ff;
   assign fold8  = (fold16 >= LV_X8) ? fold16 - LV_X8 : fold16;
   assign fold4  = (fold8 >= LV_X4) ? fold8 - LV_X4 : fold8;
   assign fold2  = (rem_ff >= LV_X2) ? rem_ff - LV_X2 : rem_ff;
   assign fold1  = (fold2 >= LV_X1) ? fold2 - LV_X1 : fold2;

   obbo_ram #(
      .WIDTH (RECW),
      .DEPTH (MAX_ORDERS)
   ) u_orders (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (RECW'(ram_wd)),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // level cell chain; cell 0 starts from an empty book
   for (genvar i = 0; i < LEVELS; i++) begin : g_cell
      obbo_level_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd_ff),
         .tok_i   ((i == 0) ? scan_start_ff : tok[(i == 0) ? 0 : i-1]),
         .cand_i  ((i == 0) ? best_type'('0) : cand[(i == 0) ? 0 : i-1]),
         .tok_o   (tok[i]),
         .cand_o  (cand[i]),
         .clash_o (clash[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      wipe_addr_in  = wipe_addr_ff;
      wipe_rsp_in   = wipe_rsp_ff;
      func_in       = func_ff;
      id_in         = id_ff;
      side_in       = side_ff;
      price_in      = price_ff;
      qty_in        = qty_ff;
      status_in     = status_ff;
      pbits_in      = pbits_ff;
      part_in       = part_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      cmd_in        = cmd_ff;
      cmd_in.op     = CELL_NOP;
      scan_start_in = 1'b0;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_best_in   = rsp_best_ff;
      ram_we        = 1'b0;
      ram_wa        = IW'({22'b0, id_ff});
      ram_wd        = '0;

      unique case (state_ff)
         S_WIPE: begin
            ram_we = 1'b1;
            ram_wa = wipe_addr_ff;
            if (wipe_addr_ff == IW'(MAX_ORDERS - 1)) begin
               wipe_addr_in = '0;
               if (wipe_rsp_ff) begin
                  wipe_rsp_in   = 1'b0;
                  scan_start_in = 1'b1;
                  state_in      = S_SCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               wipe_addr_in = wipe_addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               func_in  = req.func;
               id_in    = req.order_id;
               side_in  = req.side;
               price_in = req.price;
               qty_in   = req.quantity;
               state_in = S_READ;
            end
         end
         S_READ: begin
            status_in = STAT_OK;
            rem_in    = '0;
            step_in   = '0;
            cmd_in.quantity = qty_ff;
            case (func_ff)
               FUNC_ADD: begin
                  cmd_in.side  = side_ff;
                  cmd_in.price = price_ff;
                  pbits_in     = price_ff;
                  if (!id_ok) begin
                     status_in     = STAT_UNKNOWN;
                     scan_start_in = 1'b1;
                     state_in      = S_SCAN;
                  end else if (rec.live) begin
                     status_in     = STAT_DUP;
                     scan_start_in = 1'b1;
                     state_in      = S_SCAN;
                  end else begin
                     state_in = S_MOD;
                  end
               end
               FUNC_MODIFY, FUNC_CANCEL: begin
                  cmd_in.side         = rec.side;
                  cmd_in.price        = rec.price;
                  cmd_in.old_quantity = rec.quantity;
                  pbits_in            = rec.price;
                  if (!id_ok || !rec.live) begin
                     status_in     = STAT_UNKNOWN;
                     scan_start_in = 1'b1;
                     state_in      = S_SCAN;
                  end else begin
                     state_in = S_MOD;
                  end
               end
               FUNC_CLEAR: begin
                  cmd_in.op   = CELL_CLEAR;
                  wipe_rsp_in = 1'b1;
                  state_in    = S_WIPE;
               end
               default: begin
                  scan_start_in = 1'b1;
                  state_in      = S_SCAN;
               end
            endcase
         end
         S_MOD: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               2'd0: begin
                  // residues of the set price bits, summed in groups of four
                  for (int g = 0; g < 8; g++) begin
                     part_in[g] = (term[4*g] + term[4*g+1]) + (term[4*g+2] + term[4*g+3]);
                  end
               end
               2'd1: begin
                  // full residue sum, below 32 * LEVELS
                  rem_in = ((part_ext[0] + part_ext[1]) + (part_ext[2] + part_ext[3]))
                         + ((part_ext[4] + part_ext[5]) + (part_ext[6] + part_ext[7]));
               end
               2'd2: begin
                  rem_in = fold4;
               end
               default: begin
                  // slot goes out now so the clash flags settle during the check cycle
                  rem_in      = fold1;
                  cmd_in.slot = 16'(fold1[LW-1:0]);
                  state_in    = S_CHECK;
               end
            endcase
         end
         S_CHECK: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            // clash flags reflect the slot set during the check cycle
            if ((func_ff == FUNC_ADD) && (|clash)) begin
               status_in     = STAT_CLASH;
               scan_start_in = 1'b1;
               state_in      = S_SCAN;
            end else begin
               case (func_ff)
                  FUNC_ADD:    cmd_in.op = CELL_ADD;
                  FUNC_MODIFY: cmd_in.op = CELL_MODIFY;
                  default:     cmd_in.op = CELL_CANCEL;
               endcase
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            ram_we          = 1'b1;
            ram_wa          = IW'({22'b0, id_ff});
            ram_wd.live     = (func_ff != FUNC_CANCEL);
            ram_wd.side     = cmd_ff.side;
            ram_wd.price    = cmd_ff.price;
            ram_wd.quantity = (func_ff == FUNC_CANCEL) ? cmd_ff.old_quantity : qty_ff;
            scan_start_in   = 1'b1;
            state_in        = S_SCAN;
         end
         S_SCAN: begin
            if (tok[LEVELS-1]) begin
               res_in   = cand[LEVELS-1];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_best_in   = res_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_WIPE;
         wipe_addr_ff  <= '0;
         wipe_rsp_ff   <= 1'b0;
         scan_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cmd_ff.op     <= CELL_NOP;
      end else begin
         state_ff      <= state_in;
         wipe_addr_ff  <= wipe_addr_in;
         wipe_rsp_ff   <= wipe_rsp_in;
         scan_start_ff <= scan_start_in;
         rsp_valid_ff  <= rsp_valid_in;
         cmd_ff.op     <= cmd_in.op;
      end
      cmd_ff.slot         <= cmd_in.slot;
      cmd_ff.side         <= cmd_in.side;
      cmd_ff.price        <= cmd_in.price;
      cmd_ff.quantity     <= cmd_in.quantity;
      cmd_ff.old_quantity <= cmd_in.old_quantity;
      func_ff       <= func_in;
      id_ff         <= id_in;
      side_ff       <= side_in;
      price_ff      <= price_in;
      qty_ff        <= qty_in;
      status_ff     <= status_in;
      pbits_ff      <= pbits_in;
      part_ff       <= part_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_best_ff   <= rsp_best_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.bid_valid = rsp_best_ff.bid_valid;
   assign rsp.bid_price = rsp_best_ff.bid_valid ? rsp_best_ff.bid_price : '0;
   assign rsp.bid_total = rsp_best_ff.bid_valid ? rsp_best_ff.bid_total : '0;
   assign rsp.ask_valid = rsp_best_ff.ask_valid;
   assign rsp.ask_price = rsp_best_ff.ask_valid ? rsp_best_ff.ask_price : '0;
   assign rsp.ask_total = rsp_best_ff.ask_valid ? rsp_best_ff.ask_total : '0;
endmodule

// ----- sv/obbo_checker.sv -----
// Port-level checks for the order book top-of-book unit, bound to the top level.
// Depends on order_book_best_bid_offer_unit.
module obbo_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic        rsp_bid_valid,
   input logic [31:0] rsp_bid_price,
   input logic [41:0] rsp_bid_total,
   input logic        rsp_ask_valid,
   input logic [31:0] rsp_ask_price,
   input logic [41:0] rsp_ask_total
);
   // one request in flight: ready drops right after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_bid_price) && $stable(rsp_ask_price)))
      else $error("stalled response changed");

   a_empty_bid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bid_valid) |-> (rsp_bid_price == '0 && rsp_bid_total == '0))
      else $error("empty bid side reports a level");

   a_empty_ask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ask_valid) |-> (rsp_ask_price == '0 && rsp_ask_total == '0))
      else $error("empty ask side reports a level");
endmodule

bind order_book_best_bid_offer_unit obbo_checker u_obbo_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_status    (rsp.status),
   .rsp_bid_valid (rsp.bid_valid),
   .rsp_bid_price (rsp.bid_price),
   .rsp_bid_total (rsp.bid_total),
   .rsp_ask_valid (rsp.ask_valid),
   .rsp_ask_price (rsp.ask_price),
   .rsp_ask_total (rsp.ask_total)
);
